[rtl/core/drs_pkg.sv]
// Shared types, codes and microcode program of the dimmer ramp controller.
package drs_pkg;

    // Item payloads
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_UP   = 2'd2,
        MODE_DOWN = 2'd3
    } t_mode;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now_ms;
        logic [7:0]  status_byte;
        logic [15:0] target_level;
    } t_in_item;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] level;
    } t_out_item;

    // Event commands
    localparam logic [2:0] CMD_STATUS    = 3'd0;
    localparam logic [2:0] CMD_SET_LEVEL = 3'd1;
    localparam logic [2:0] CMD_TURN_ON   = 3'd2;
    localparam logic [2:0] CMD_TURN_OFF  = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_DURATION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_EPSILON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LIGHT_ON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LIGHT_OFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BOTTOM   = 3'd5;

    localparam logic [15:0] FULL_SCALE    = 16'hFFFF;
    localparam logic [15:0] EPSILON_RESET = 16'd655;
    localparam int          QUO_BITS      = 16;

    // Microcode
    typedef logic [2:0] t_step;

    localparam t_step STEP_WAIT   = 3'd0;
    localparam t_step STEP_PREP   = 3'd1;
    localparam t_step STEP_SATCHK = 3'd2;
    localparam t_step STEP_DIV    = 3'd3;
    localparam t_step STEP_LEVEL  = 3'd4;
    localparam t_step STEP_APPLY  = 3'd5;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_PREP,
        OP_SATCHK,
        OP_DIV,
        OP_LEVEL,
        OP_APPLY,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_NO_INPUT,
        STALL_OUT_BUSY
    } t_stall;

    typedef enum logic [2:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_NO_DIV,
        JMP_SAT,
        JMP_CNT_NZ
    } t_jcond;

    typedef struct packed {
        t_op    op;
        t_stall stall;
        t_jcond jcond;
        t_step  target;
    } t_uword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic no_div;
        logic sat;
        logic cnt_nz;
    } t_seq_flags;

    // Current control word and whether it executes this cycle
    typedef struct packed {
        t_uword uw;
        logic   go;
    } t_seq_ctrl;

    // Program: wait, product, saturation check, divide loop, level, apply
    function automatic t_uword mc_rom(t_step s);
        t_uword uw;
        case (s)
            STEP_WAIT:   uw = '{op: OP_WAIT,   stall: STALL_NO_INPUT, jcond: JMP_NEVER,
                                target: STEP_WAIT};
            STEP_PREP:   uw = '{op: OP_PREP,   stall: STALL_NONE,     jcond: JMP_NO_DIV,
                                target: STEP_LEVEL};
            STEP_SATCHK: uw = '{op: OP_SATCHK, stall: STALL_NONE,     jcond: JMP_SAT,
                                target: STEP_LEVEL};
            STEP_DIV:    uw = '{op: OP_DIV,    stall: STALL_NONE,     jcond: JMP_CNT_NZ,
                                target: STEP_DIV};
            STEP_LEVEL:  uw = '{op: OP_LEVEL,  stall: STALL_NONE,     jcond: JMP_NEVER,
                                target: STEP_WAIT};
            STEP_APPLY:  uw = '{op: OP_APPLY,  stall: STALL_OUT_BUSY, jcond: JMP_ALWAYS,
                                target: STEP_WAIT};
            default:     uw = '{op: OP_NOP,    stall: STALL_NONE,     jcond: JMP_ALWAYS,
                                target: STEP_WAIT};
        endcase
        return uw;
    endfunction

endpackage

[rtl/core/drs_seq.sv]
// Microcode sequencer: step counter, program ROM, stall and jump logic.
module drs_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  drs_pkg::t_seq_flags    i_flags,
    output drs_pkg::t_seq_ctrl     o_ctrl
);
    import drs_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   stalled;
    logic   take;

    // Decode the current step and pick the next one
    always_comb begin
        uw = mc_rom(r_step);

        case (uw.stall)
            STALL_NONE:     stalled = 1'b0;
            STALL_NO_INPUT: stalled = !i_flags.in_valid;
            STALL_OUT_BUSY: stalled = i_flags.out_busy;
            default:        stalled = 1'b0;
        endcase

        case (uw.jcond)
            JMP_NEVER:  take = 1'b0;
            JMP_ALWAYS: take = 1'b1;
            JMP_NO_DIV: take = i_flags.no_div;
            JMP_SAT:    take = i_flags.sat;
            JMP_CNT_NZ: take = i_flags.cnt_nz;
            default:    take = 1'b0;
        endcase

        if (stalled) begin
            n_step = r_step;
        end else if (take) begin
            n_step = uw.target;
        end else begin
            n_step = t_step'(r_step + 3'd1);
        end

        o_ctrl.uw = uw;
        o_ctrl.go = !stalled;
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[rtl/core/dimmer_ramp_state_machine_unit.sv]
// Top level of the dimmer ramp controller: configuration, state and datapath.
//
// One event is taken at a time. An event that finds a ramp in progress (with a
// non-zero dim duration) goes through these steps from transfer in to result
// ready: accept, the elapsed-time product, a saturation check, the restoring
// divider that forms the 16-bit ramp step one quotient bit per cycle, forming
// the level, and updating state and loading the output register. A saturated
// step skips the divider; any other event also skips the saturation check.
// The output register holds the result until taken; a new event is accepted
// meanwhile, but its update waits for the slot to free.
module dimmer_ramp_state_machine_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  drs_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output drs_pkg::t_out_item                o_out,
    input  logic                              i_cfg_we,
    input  logic [drs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [drs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import drs_pkg::*;

    // Configuration
    logic [31:0] r_dim_duration;
    logic [15:0] r_level_eps;
    logic [7:0]  r_code_on;
    logic [7:0]  r_code_top;
    logic [7:0]  r_code_off;
    logic [7:0]  r_code_bottom;

    // Controller state
    t_mode       r_mode;
    logic [15:0] r_steady;
    logic [15:0] r_start_level;
    logic [15:0] r_target_level;
    logic [31:0] r_start_time;

    // Working registers
    t_in_item    r_item;
    logic [47:0] r_num;
    logic [31:0] r_rem;
    logic [15:0] r_quo;
    logic [3:0]  r_cnt;
    logic [15:0] r_cur;
    t_out_item   r_out;
    logic        r_out_valid;

    // Next state from the apply step
    t_mode       n_mode;
    logic [15:0] n_steady;
    logic [15:0] n_start_level;
    logic [15:0] n_target_level;
    logic [31:0] n_start_time;
    logic [15:0] n_level;

    t_seq_flags  flags;
    t_seq_ctrl   ctrl;
    logic        do_op;

    logic [31:0] dt;
    logic [47:0] num_prod;
    logic        sat;
    logic [32:0] rem_trial;
    logic [32:0] rem_diff;
    logic        rem_ge;
    logic        ramping;
    logic [16:0] up_sum;
    logic [15:0] up_v;
    logic [15:0] up_lvl;
    logic [15:0] dn_v;
    logic [15:0] dn_lvl;
    logic [15:0] cur_level;
    logic [15:0] diff;
    logic        up_done;
    logic        dn_done;

    // Sequencer
    drs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    assign do_op      = ctrl.go;
    assign o_in_ready = (ctrl.uw.op == OP_WAIT);
    assign o_out_valid = r_out_valid;
    assign o_out      = r_out;

    // Elapsed time times full scale, and one restoring divider step
    always_comb begin
        dt        = r_item.now_ms - r_start_time;
        num_prod  = {dt, 16'h0000} - {16'h0000, dt};
        sat       = (r_num >= {r_dim_duration, 16'h0000});
        rem_trial = {r_rem, r_num[15]};
        rem_ge    = (rem_trial >= {1'b0, r_dim_duration});
        rem_diff  = rem_trial - {1'b0, r_dim_duration};
        ramping   = (r_mode == MODE_UP) || (r_mode == MODE_DOWN);
    end

    assign flags.in_valid = i_in_valid;
    assign flags.out_busy = r_out_valid && !i_out_ready;
    assign flags.no_div   = !ramping || (r_dim_duration == 32'd0);
    assign flags.sat      = sat;
    assign flags.cnt_nz   = (r_cnt != 4'd0);

    // Level at the event time from the current state
    always_comb begin
        up_sum = {1'b0, r_start_level} + {1'b0, r_quo};
        up_v   = up_sum[16] ? FULL_SCALE : up_sum[15:0];
        up_lvl = (up_v < r_target_level) ? up_v : r_target_level;
        dn_v   = (r_start_level > r_quo) ? (r_start_level - r_quo) : 16'd0;
        dn_lvl = (dn_v > r_target_level) ? dn_v : r_target_level;
        case (r_mode)
            MODE_ON:   cur_level = r_steady;
            MODE_UP:   cur_level = (r_dim_duration == 32'd0) ? r_target_level : up_lvl;
            MODE_DOWN: cur_level = (r_dim_duration == 32'd0) ? r_target_level : dn_lvl;
            default:   cur_level = 16'd0;
        endcase
    end

    // Apply the event to the state and form the result level
    always_comb begin
        n_mode         = r_mode;
        n_steady       = r_steady;
        n_start_level  = r_start_level;
        n_target_level = r_target_level;
        n_start_time   = r_start_time;

        diff    = (r_item.target_level > r_cur) ? (r_item.target_level - r_cur)
                                                : (r_cur - r_item.target_level);
        up_done = ({1'b0, r_cur} + {1'b0, r_level_eps}) >= {1'b0, r_target_level};
        dn_done = {1'b0, r_cur} <= ({1'b0, r_target_level} + {1'b0, r_level_eps});

        case (r_item.cmd)
            CMD_STATUS: begin
                if (r_item.status_byte == r_code_on || r_item.status_byte == r_code_top) begin
                    n_mode   = MODE_ON;
                    n_steady = FULL_SCALE;
                end else if (r_item.status_byte == r_code_off ||
                             r_item.status_byte == r_code_bottom) begin
                    n_mode = MODE_OFF;
                end
            end
            CMD_SET_LEVEL: begin
                if (r_item.target_level < r_level_eps) begin
                    n_mode = MODE_OFF;
                end else if (r_dim_duration == 32'd0 || diff < r_level_eps) begin
                    n_mode   = MODE_ON;
                    n_steady = r_item.target_level;
                end else begin
                    n_start_level  = r_cur;
                    n_target_level = r_item.target_level;
                    n_start_time   = r_item.now_ms;
                    n_mode         = (r_item.target_level > r_cur) ? MODE_UP : MODE_DOWN;
                end
            end
            CMD_TURN_ON: begin
                n_mode   = MODE_ON;
                n_steady = FULL_SCALE;
            end
            CMD_TURN_OFF: begin
                n_mode = MODE_OFF;
            end
            CMD_TICK: begin
                if (r_mode == MODE_UP && up_done) begin
                    n_mode   = MODE_ON;
                    n_steady = r_target_level;
                end else if (r_mode == MODE_DOWN && dn_done) begin
                    if (r_target_level < r_level_eps) begin
                        n_mode = MODE_OFF;
                    end else begin
                        n_mode   = MODE_ON;
                        n_steady = r_target_level;
                    end
                end
            end
            default: begin
            end
        endcase

        // A ramp left running or just started reads as the level sampled before
        case (n_mode)
            MODE_ON:  n_level = n_steady;
            MODE_OFF: n_level = 16'd0;
            default:  n_level = r_cur;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_duration <= 32'd0;
            r_level_eps    <= EPSILON_RESET;
            r_code_on      <= 8'd0;
            r_code_top     <= 8'd0;
            r_code_off     <= 8'd0;
            r_code_bottom  <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIM_DURATION:   r_dim_duration <= i_cfg_data;
                CFG_LEVEL_EPSILON:  r_level_eps    <= i_cfg_data[15:0];
                CFG_CODE_LIGHT_ON:  r_code_on      <= i_cfg_data[7:0];
                CFG_CODE_TOP:       r_code_top     <= i_cfg_data[7:0];
                CFG_CODE_LIGHT_OFF: r_code_off     <= i_cfg_data[7:0];
                CFG_CODE_BOTTOM:    r_code_bottom  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_OFF;
            r_steady       <= 16'd0;
            r_start_level  <= 16'd0;
            r_target_level <= 16'd0;
            r_start_time   <= 32'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (ctrl.uw.op == OP_APPLY && do_op) begin
                r_mode         <= n_mode;
                r_steady       <= n_steady;
                r_start_level  <= n_start_level;
                r_target_level <= n_target_level;
                r_start_time   <= n_start_time;
                r_out_valid    <= 1'b1;
            end
        end
    end

    // Datapath steps driven by the control word
    always_ff @(posedge i_clk) begin
        if (do_op) begin
            case (ctrl.uw.op)
                OP_WAIT: begin
                    r_item <= i_in;
                end
                OP_PREP: begin
                    r_num <= num_prod;
                end
                OP_SATCHK: begin
                    r_rem <= r_num[47:16];
                    r_quo <= sat ? FULL_SCALE : 16'd0;
                    r_cnt <= 4'(QUO_BITS - 1);
                end
                OP_DIV: begin
                    r_rem <= rem_ge ? rem_diff[31:0] : rem_trial[31:0];
                    r_quo <= {r_quo[14:0], rem_ge};
                    r_num <= {r_num[46:0], 1'b0};
                    r_cnt <= r_cnt - 4'd1;
                end
                OP_LEVEL: begin
                    r_cur <= cur_level;
                end
                OP_APPLY: begin
                    r_out.mode  <= n_mode;
                    r_out.level <= n_level;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/drs_check.sv]
// Port-level checks for the dimmer ramp controller, bound to the top level.
module drs_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  drs_pkg::t_out_item    i_out_data
);
    import drs_pkg::*;

    // One event at a time: busy straight after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after a transfer in");

    // No result can appear in the cycle after an event is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared too early after a transfer in");

    // Off always reports a zero level
    a_off_is_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.mode == MODE_OFF) |-> (i_out_data.level == 16'd0))
        else $error("off mode with non-zero level");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind dimmer_ramp_state_machine_unit drs_check u_drs_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out)
);

[sim/dimmer_ramp_state_machine_checker.sv]
// Scoreboard for the dimmer ramp controller: predicts each event's result and compares it.
module dimmer_ramp_state_machine_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  drs_pkg::t_in_item                 i_in,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  drs_pkg::t_out_item                i_out,
    input  logic                              i_cfg_we,
    input  logic [drs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [drs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    import drs_pkg::*;

    // Register copies
    logic [31:0] dim_ms;
    logic [15:0] eps;
    logic [7:0]  code_on, code_top, code_off, code_bottom;

    // Lamp state
    t_mode       lamp_mode;
    logic [15:0] hold_level;
    logic [15:0] sweep_from;
    logic [15:0] sweep_to;
    logic [31:0] sweep_t0;

    t_out_item   awaited_results[$];
    t_out_item   want_res;
    int          mismatches;
    int          checked;

    // Fraction of full scale covered since the ramp began, saturated
    function automatic logic [15:0] ramp_advance(input logic [31:0] now);
        logic [31:0] dt;
        logic [63:0] q;
        dt = now - sweep_t0;
        q  = ({32'd0, dt} * 64'd65535) / {32'd0, dim_ms};
        return (q > 64'd65535) ? FULL_SCALE : q[15:0];
    endfunction

    // Level seen at a given time in the present mode
    function automatic logic [15:0] level_at(input logic [31:0] now);
        logic [15:0] s;
        logic [16:0] v;
        logic [15:0] d;
        case (lamp_mode)
            MODE_ON: begin
                return hold_level;
            end
            MODE_UP: begin
                if (dim_ms == 32'd0) return sweep_to;
                s = ramp_advance(now);
                v = {1'b0, sweep_from} + {1'b0, s};
                if (v > 17'h0FFFF) v = 17'h0FFFF;
                return (v[15:0] < sweep_to) ? v[15:0] : sweep_to;
            end
            MODE_DOWN: begin
                if (dim_ms == 32'd0) return sweep_to;
                s = ramp_advance(now);
                d = (sweep_from > s) ? sweep_from - s : 16'd0;
                return (d > sweep_to) ? d : sweep_to;
            end
            default: begin
                return 16'd0;
            end
        endcase
    endfunction

    // Apply one event to the lamp state and return mode and level after it
    function automatic t_out_item predict_event(input t_in_item ev);
        t_out_item   res;
        logic [15:0] cur;
        logic [15:0] diff;
        case (ev.cmd)
            CMD_STATUS: begin
                if (ev.status_byte == code_on || ev.status_byte == code_top) begin
                    lamp_mode  = MODE_ON;
                    hold_level = FULL_SCALE;
                end else if (ev.status_byte == code_off || ev.status_byte == code_bottom) begin
                    lamp_mode = MODE_OFF;
                end
            end
            CMD_SET_LEVEL: begin
                if (ev.target_level < eps) begin
                    lamp_mode = MODE_OFF;
                end else if (dim_ms == 32'd0) begin
                    lamp_mode  = MODE_ON;
                    hold_level = ev.target_level;
                end else begin
                    cur  = level_at(ev.now_ms);
                    diff = (ev.target_level > cur) ? ev.target_level - cur
                                                   : cur - ev.target_level;
                    if (diff < eps) begin
                        lamp_mode  = MODE_ON;
                        hold_level = ev.target_level;
                    end else begin
                        sweep_from = cur;
                        sweep_to   = ev.target_level;
                        sweep_t0   = ev.now_ms;
                        lamp_mode  = (ev.target_level > cur) ? MODE_UP : MODE_DOWN;
                    end
                end
            end
            CMD_TURN_ON: begin
                lamp_mode  = MODE_ON;
                hold_level = FULL_SCALE;
            end
            CMD_TURN_OFF: begin
                lamp_mode = MODE_OFF;
            end
            CMD_TICK: begin
                cur = level_at(ev.now_ms);
                if (lamp_mode == MODE_UP) begin
                    if ({1'b0, cur} + {1'b0, eps} >= {1'b0, sweep_to}) begin
                        lamp_mode  = MODE_ON;
                        hold_level = sweep_to;
                    end
                end else if (lamp_mode == MODE_DOWN) begin
                    if ({1'b0, cur} <= {1'b0, sweep_to} + {1'b0, eps}) begin
                        if (sweep_to < eps) begin
                            lamp_mode = MODE_OFF;
                        end else begin
                            lamp_mode  = MODE_ON;
                            hold_level = sweep_to;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.mode  = lamp_mode;
        res.level = level_at(ev.now_ms);
        return res;
    endfunction

    // Track transfers and registers; compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dim_ms      = 32'd0;
            eps         = EPSILON_RESET;
            code_on     = 8'd0;
            code_top    = 8'd0;
            code_off    = 8'd0;
            code_bottom = 8'd0;
            lamp_mode   = MODE_OFF;
            hold_level  = 16'd0;
            sweep_from  = 16'd0;
            sweep_to    = 16'd0;
            sweep_t0    = 32'd0;
            awaited_results.delete();
            mismatches  = 0;
            checked     = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing awaited: mode %0d level %0d",
                             $time, i_out.mode, i_out.level);
                    mismatches++;
                end else begin
                    want_res = awaited_results.pop_front();
                    checked++;
                    if (i_out.mode !== want_res.mode) begin
                        $display("%0t: mode mismatch: expected %0d actual %0d",
                                 $time, want_res.mode, i_out.mode);
                        mismatches++;
                    end
                    if (i_out.level !== want_res.level) begin
                        $display("%0t: level mismatch: expected %0d actual %0d",
                                 $time, want_res.level, i_out.level);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(predict_event(i_in));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIM_DURATION:   dim_ms      = i_cfg_data;
                    CFG_LEVEL_EPSILON:  eps         = i_cfg_data[15:0];
                    CFG_CODE_LIGHT_ON:  code_on     = i_cfg_data[7:0];
                    CFG_CODE_TOP:       code_top    = i_cfg_data[7:0];
                    CFG_CODE_LIGHT_OFF: code_off    = i_cfg_data[7:0];
                    CFG_CODE_BOTTOM:    code_bottom = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
        o_checked    <= checked;
    end

endmodule

[sim/tb_dimmer_ramp_state_machine_unit.sv]
// Testbench top for the dimmer ramp controller: stimulus, flow control and verdict.
module tb_dimmer_ramp_state_machine_unit;
    import drs_pkg::*;

    localparam logic [2:0] CMD_RESERVED_5 = 3'd5;
    localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
    localparam logic [2:0] CMD_RESERVED_7 = 3'd7;
    localparam int RANDOM_PER_PHASE = 185;
    localparam int STALL_LIMIT      = 4000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_item               i_in;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int checked_count;

    // Stimulus bookkeeping
    logic [31:0] wall_ms;
    logic [31:0] reg_dim;
    logic [15:0] reg_eps;
    logic [7:0]  reg_codes[4];
    logic [15:0] last_tgt;
    int          burst_left;
    int          events_sent;
    int          settings_used;
    int          cmd_seen[8];

    // Receiver stall state
    int          rx_cycles = 0;
    int          rx_style  = 0;
    int          rx_run    = 0;
    logic        rx_hold   = 1'b1;
    logic        rx_next;

    int          idle_cycles = 0;

    dimmer_ramp_state_machine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    dimmer_ramp_state_machine_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side: always ready, coin toss, long runs, or one cycle in three
    always @(posedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 400 == 0) rx_style = $urandom_range(0, 3);
        case (rx_style)
            0: rx_next = 1'b1;
            1: rx_next = 1'($urandom_range(0, 1));
            2: begin
                if (rx_run == 0) begin
                    rx_hold = ~rx_hold;
                    rx_run  = rx_hold ? $urandom_range(1, 10) : $urandom_range(1, 30);
                end
                rx_run--;
                rx_next = rx_hold;
            end
            default: rx_next = (rx_cycles % 3 == 0);
        endcase
        i_out_ready <= rx_next;
    end

    // Drop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one event and hold it until the transfer, then pace the next one
    task automatic issue(input logic [2:0] cmd, input logic [31:0] adv,
                         input logic [7:0] sb, input logic [15:0] tgt);
        t_in_item ev;
        int       gap;
        wall_ms         = wall_ms + adv;
        ev.cmd          = cmd;
        ev.now_ms       = wall_ms;
        ev.status_byte  = sb;
        ev.target_level = tgt;
        i_in_valid <= 1'b1;
        i_in       <= ev;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        cmd_seen[cmd]++;
        events_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Reprogram every register once the block has gone quiet
    task automatic program_regs(input logic [31:0] dim, input logic [15:0] eps,
                                input logic [7:0] on_c, input logic [7:0] top_c,
                                input logic [7:0] off_c, input logic [7:0] bot_c);
        wait_drained();
        write_reg(CFG_DIM_DURATION, dim);
        write_reg(CFG_LEVEL_EPSILON, {16'd0, eps});
        write_reg(CFG_CODE_LIGHT_ON, {24'd0, on_c});
        write_reg(CFG_CODE_TOP, {24'd0, top_c});
        write_reg(CFG_CODE_LIGHT_OFF, {24'd0, off_c});
        write_reg(CFG_CODE_BOTTOM, {24'd0, bot_c});
        i_cfg_we     <= 1'b0;
        reg_dim      = dim;
        reg_eps      = eps;
        reg_codes[0] = on_c;
        reg_codes[1] = top_c;
        reg_codes[2] = off_c;
        reg_codes[3] = bot_c;
        settings_used++;
    endtask

    // One random event: mostly ticks and level requests, small time steps against the ramp
    task automatic random_event();
        int          pick;
        int          near;
        logic [2:0]  cmd;
        logic [31:0] adv;
        logic [31:0] span;
        logic [7:0]  sb;
        logic [15:0] tgt;
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd = CMD_TICK;
        else if (pick < 58) cmd = CMD_SET_LEVEL;
        else if (pick < 72) cmd = CMD_STATUS;
        else if (pick < 81) cmd = CMD_TURN_ON;
        else if (pick < 90) cmd = CMD_TURN_OFF;
        else if (pick < 94) cmd = CMD_RESERVED_5;
        else if (pick < 97) cmd = CMD_RESERVED_6;
        else                cmd = CMD_RESERVED_7;

        span = (reg_dim == 32'd0 || reg_dim > 32'd20000) ? 32'd500 : reg_dim / 6 + 1;
        pick = $urandom_range(0, 99);
        if (pick < 8)       adv = 32'd0;
        else if (pick < 75) adv = $urandom_range(1, span);
        else if (pick < 88) adv = $urandom_range(1, 1 << 20);
        else if (pick < 95) adv = $urandom();
        else                adv = 32'd0 - $urandom_range(1, 5000);

        if ($urandom_range(0, 99) < 60) sb = reg_codes[$urandom_range(0, 3)];
        else                            sb = 8'($urandom_range(0, 255));

        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            tgt = 16'd0;
        end else if (pick < 20) begin
            tgt = FULL_SCALE;
        end else if (pick < 35) begin
            near = int'(reg_eps) + $urandom_range(0, 6) - 3;
            tgt  = (near < 0) ? 16'd0 : (near > 65535) ? FULL_SCALE : near[15:0];
        end else if (pick < 55) begin
            near = int'(last_tgt) + $urandom_range(0, 2 * (int'(reg_eps) + 16))
                   - (int'(reg_eps) + 16);
            tgt  = (near < 0) ? 16'd0 : (near > 65535) ? FULL_SCALE : near[15:0];
        end else begin
            tgt = 16'($urandom_range(0, 65535));
        end
        if (cmd == CMD_SET_LEVEL) last_tgt = tgt;
        issue(cmd, adv, sb, tgt);
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) == 0) wait_drained();
            random_event();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        wall_ms       = 32'd0;
        reg_dim       = 32'd0;
        reg_eps       = EPSILON_RESET;
        reg_codes     = '{8'd0, 8'd0, 8'd0, 8'd0};
        last_tgt      = 16'd32768;
        burst_left    = 1;
        events_sent   = 0;
        settings_used = 1;
        foreach (cmd_seen[k]) cmd_seen[k] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers as left by reset
        random_phase(RANDOM_PER_PHASE);

        // Directed: each status role, level extremes, ramps across the time wrap
        program_regs(32'd1000, 16'd655, 8'h11, 8'h22, 8'h33, 8'h44);
        wall_ms = 32'hFFFF_FC00;
        issue(CMD_STATUS, 32'd0, 8'h11, 16'd0);
        issue(CMD_STATUS, 32'd5, 8'h33, FULL_SCALE);
        issue(CMD_STATUS, 32'd5, 8'h22, 16'd0);
        issue(CMD_STATUS, 32'd5, 8'h44, 16'd0);
        issue(CMD_STATUS, 32'd5, 8'hFF, 16'd0);
        issue(CMD_STATUS, 32'd5, 8'h00, 16'd0);
        issue(CMD_TURN_ON, 32'd5, 8'h00, 16'd0);
        issue(CMD_SET_LEVEL, 32'd5, 8'h00, 16'd0);
        issue(CMD_SET_LEVEL, 32'd5, 8'h00, FULL_SCALE);
        issue(CMD_TICK, 32'd250, 8'h00, 16'd0);
        issue(CMD_TICK, 32'd600, 8'h00, 16'd0);
        issue(CMD_TICK, 32'd400, 8'h00, 16'd0);
        issue(CMD_SET_LEVEL, 32'd5, 8'h00, 16'd32768);
        issue(CMD_TICK, 32'd100, 8'h00, 16'd0);
        issue(CMD_SET_LEVEL, 32'd50, 8'h00, 16'd40000);
        issue(CMD_TURN_ON, 32'd5, 8'h00, 16'd0);
        issue(CMD_SET_LEVEL, 32'd5, 8'h00, 16'd65000);
        issue(CMD_RESERVED_5, 32'd5, 8'hA5, 16'h5A5A);
        issue(CMD_RESERVED_6, 32'd5, 8'h5A, 16'hA5A5);
        issue(CMD_RESERVED_7, 32'd5, 8'hFF, FULL_SCALE);
        issue(CMD_TURN_OFF, 32'd5, 8'h00, 16'd0);
        issue(CMD_TICK, 32'd5, 8'h00, 16'd0);
        issue(CMD_TURN_ON, 32'd5, 8'h00, 16'd0);
        issue(CMD_SET_LEVEL, 32'd5, 8'h00, 16'd700);
        issue(CMD_TICK, 32'd100, 8'h00, 16'd0);

        // Raise the threshold over the ramp target so the pending ramp ends in off
        program_regs(32'd1000, 16'd1000, 8'h11, 8'h22, 8'h33, 8'h44);
        issue(CMD_TICK, 32'd2000, 8'h00, 16'd0);
        random_phase(RANDOM_PER_PHASE);

        // Instant switching with a zero threshold
        program_regs(32'd0, 16'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_phase(RANDOM_PER_PHASE);

        // Slowest ramp, widest threshold, every code on one byte
        program_regs(32'hFFFF_FFFF, FULL_SCALE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_phase(RANDOM_PER_PHASE);

        // Fastest ramp, tightest non-zero threshold
        program_regs(32'd1, 16'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        random_phase(RANDOM_PER_PHASE);

        // Mid-range settings with codes that often collide
        repeat (5) begin
            program_regs($urandom_range(1, 5000), 16'($urandom_range(0, 3000)),
                         8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                         8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
            random_phase(RANDOM_PER_PHASE);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Ran %0d events over %0d register settings; %0d results checked.",
                 events_sent, settings_used, checked_count);
        $display("By command: status %0d, set level %0d, on %0d, off %0d, tick %0d, spare %0d.",
                 cmd_seen[CMD_STATUS], cmd_seen[CMD_SET_LEVEL], cmd_seen[CMD_TURN_ON],
                 cmd_seen[CMD_TURN_OFF], cmd_seen[CMD_TICK],
                 cmd_seen[CMD_RESERVED_5] + cmd_seen[CMD_RESERVED_6]
                 + cmd_seen[CMD_RESERVED_7]);
        if (pending != 0) $display("%0d predicted results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
